@@ design/trwr_pkg.sv @@
// Shared types, codes and constants of the tagged reply word receiver.
`timescale 1ns / 1ps

package trwr_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int ACTION_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 16;
    localparam int EVENT_W   = 3;
    localparam int TICKS_W   = 24;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_START_READY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RX_WORD     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_EXPECT_ACK  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_EXPECT_BYTES = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TICK        = 3'd4;

    // Result events.
    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_READY   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ACK     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_BYTE    = 3'd3;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd4;
    localparam logic [EVENT_W-1:0] EV_IGNORED = 3'd5;

    // Register index of timeout_ticks.
    localparam logic REG_TIMEOUT_TICKS = 1'b0;

    localparam logic [BYTE_W-1:0]  READY_DATA     = 8'hC3;
    localparam logic [BYTE_W-1:0]  READY_TAG_BASE = 8'h10;
    localparam logic [BYTE_W-1:0]  ACK_MARKER     = 8'h3A;
    localparam logic [BYTE_W-1:0]  ACK_SEQ_INIT   = 8'h20;
    localparam logic [BYTE_W-1:0]  RESP_SEQ_INIT  = 8'h30;
    localparam logic [BYTE_W-1:0]  SEQ_HI_MASK    = 8'hF0;
    localparam logic [BYTE_W-1:0]  SEQ_LO_MASK    = 8'h0F;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET  = 24'd50000;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_READY = 4'b0010,
        PH_ACK   = 4'b0100,
        PH_BYTES = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } result_t;

    // Low nibble counts up modulo 16, high nibble is kept.
    function automatic logic [BYTE_W-1:0] roll_seq(input logic [BYTE_W-1:0] s);
        logic [BYTE_W-1:0] inc;
        inc = s + 8'd1;
        return (s & SEQ_HI_MASK) | (inc & SEQ_LO_MASK);
    endfunction

endpackage

@@ design/trwr_core.sv @@
// Receiver state and the per-word decision logic.
`timescale 1ns / 1ps

module trwr_core #(
    parameter int COUNT_BITS = trwr_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_accept,
    input  logic [trwr_pkg::ACTION_W-1:0] action,
    input  logic [trwr_pkg::BYTE_W-1:0]   rx_tag,
    input  logic [trwr_pkg::BYTE_W-1:0]   rx_data,
    input  logic [trwr_pkg::COUNT_W-1:0]  byte_count,
    input  logic [trwr_pkg::TICKS_W-1:0]  timeout_ticks,
    output trwr_pkg::result_t             result
);
    import trwr_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  ready_index_reg, ready_index_next;
    logic [BYTE_W-1:0]     ack_seq_reg, ack_seq_next;
    logic [BYTE_W-1:0]     resp_seq_reg, resp_seq_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;
    logic [TICKS_W-1:0]    idle_ticks_reg, idle_ticks_next;

    logic [COUNT_BITS-1:0] count_trunc;
    logic [COUNT_BITS-1:0] remaining_dec;
    logic [BYTE_W-1:0]     ready_tag;

    assign count_trunc   = COUNT_BITS'(byte_count);
    assign remaining_dec = remaining_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign ready_tag     = READY_TAG_BASE | {{(BYTE_W-1){1'b0}}, ready_index_reg};

    always_comb begin
        phase_next       = phase_reg;
        ready_index_next = ready_index_reg;
        ack_seq_next     = ack_seq_reg;
        resp_seq_next    = resp_seq_reg;
        remaining_next   = remaining_reg;
        idle_ticks_next  = idle_ticks_reg;
        result           = '{event_res: EV_NONE, data_byte: '0, last: 1'b0};

        case (action)
            ACT_START_READY: begin
                phase_next       = PH_READY;
                ready_index_next = 1'b0;
                idle_ticks_next  = '0;
            end
            ACT_RX_WORD: begin
                if (phase_reg == PH_READY && rx_data == READY_DATA && rx_tag == ready_tag) begin
                    idle_ticks_next = '0;
                    if (!ready_index_reg) begin
                        ready_index_next = 1'b1;
                    end else begin
                        ready_index_next = 1'b0;
                        ack_seq_next     = ACK_SEQ_INIT;
                        resp_seq_next    = RESP_SEQ_INIT;
                        phase_next       = PH_IDLE;
                        result.event_res = EV_READY;
                    end
                end else if (phase_reg == PH_ACK && rx_data == ACK_MARKER
                             && rx_tag == ack_seq_reg) begin
                    ack_seq_next     = roll_seq(ack_seq_reg);
                    idle_ticks_next  = '0;
                    phase_next       = PH_IDLE;
                    result.event_res = EV_ACK;
                end else if (phase_reg == PH_BYTES && rx_tag == resp_seq_reg) begin
                    resp_seq_next    = roll_seq(resp_seq_reg);
                    idle_ticks_next  = '0;
                    remaining_next   = remaining_dec;
                    result.event_res = EV_BYTE;
                    result.data_byte = rx_data;
                    if (remaining_dec == '0) begin
                        result.last = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                end else begin
                    result.event_res = EV_IGNORED;
                end
            end
            ACT_EXPECT_ACK: begin
                phase_next      = PH_ACK;
                idle_ticks_next = '0;
            end
            ACT_EXPECT_BYTES: begin
                remaining_next  = count_trunc;
                idle_ticks_next = '0;
                phase_next      = (count_trunc != '0) ? PH_BYTES : PH_IDLE;
            end
            ACT_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (idle_ticks_reg >= timeout_ticks) begin
                        phase_next       = PH_IDLE;
                        ready_index_next = 1'b0;
                        result.event_res = EV_TIMEOUT;
                    end else begin
                        idle_ticks_next = idle_ticks_reg + 24'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            ready_index_reg <= 1'b0;
            ack_seq_reg     <= ACK_SEQ_INIT;
            resp_seq_reg    <= RESP_SEQ_INIT;
            remaining_reg   <= '0;
            idle_ticks_reg  <= '0;
        end else if (item_accept) begin
            phase_reg       <= phase_next;
            ready_index_reg <= ready_index_next;
            ack_seq_reg     <= ack_seq_next;
            resp_seq_reg    <= resp_seq_next;
            remaining_reg   <= remaining_next;
            idle_ticks_reg  <= idle_ticks_next;
        end
    end

endmodule

@@ design/tagged_reply_word_receiver_unit.sv @@
// Top level of the tagged reply word receiver: stream ports, register port, result register.
// Results: one result per input transfer, valid on m_tvalid in the cycle after the transfer.
// Throughput: one transfer per cycle; the single result register frees as it is taken,
// so s_tready stays high while m_tready is high.
// Reset: synchronous, active low; clears phase, counters and sequences, sets
// timeout_ticks to 50000 and empties the result register.
`timescale 1ns / 1ps

module tagged_reply_word_receiver_unit #(
    parameter int COUNT_BITS = trwr_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] action, [10:3] rx_tag, [18:11] rx_data, [34:19] byte_count, [39:35] zero
    input  logic [trwr_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] event_res, [10:3] data_byte, [15:11] zero
    output logic [trwr_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trwr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [trwr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [trwr_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import trwr_pkg::*;

    logic [TICKS_W-1:0] timeout_reg;
    logic               cfg_write;
    logic               item_accept;
    result_t            result;
    result_t            out_reg;
    logic               out_valid_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TIMEOUT_TICKS)
                       ? {{(APB_DATA_W-TICKS_W){1'b0}}, timeout_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_write && paddr[2] == REG_TIMEOUT_TICKS) begin
            timeout_reg <= pwdata[TICKS_W-1:0];
        end
    end

    assign s_tready    = !out_valid_reg || m_tready;
    assign item_accept = s_tvalid && s_tready;

    trwr_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (item_accept),
        .action       (s_tdata[2:0]),
        .rx_tag       (s_tdata[10:3]),
        .rx_data      (s_tdata[18:11]),
        .byte_count   (s_tdata[34:19]),
        .timeout_ticks(timeout_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.data_byte, out_reg.event_res};
    assign m_tlast  = out_reg.last;

endmodule

@@ design/trwr_checker.sv @@
// Port-level checks of the tagged reply word receiver, bound to the top level.
`timescale 1ns / 1ps

module trwr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [trwr_pkg::S_DATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [trwr_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tlast,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [trwr_pkg::APB_ADDR_W-1:0] paddr,
    input logic [trwr_pkg::APB_DATA_W-1:0] pwdata,
    input logic [trwr_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);
    import trwr_pkg::*;

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Every input transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after input transfer");

    // The input side is open whenever the result register is free or being taken.
    a_ready_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input blocked with free result register");

    // Only an accepted byte carries data or the last flag.
    a_byte_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != EV_BYTE |-> !m_tlast && m_tdata[10:3] == 8'd0)
        else $error("data or last on a result that is not a byte");

endmodule

bind tagged_reply_word_receiver_unit trwr_checker u_trwr_checker (.*);

@@ verif/reply_word_checker.sv @@
// Checker for the tagged reply word receiver: watches both streams and the register port.
`timescale 1ns / 1ps

module reply_word_checker #(
    parameter int COUNT_BITS = trwr_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [2:0] action, [10:3] rx_tag, [18:11] rx_data, [34:19] byte_count, [39:35] zero
    input  logic [trwr_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] event_res, [10:3] data_byte, [15:11] zero
    input  logic [trwr_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trwr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [trwr_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [trwr_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import trwr_pkg::*;

    localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = APB_ADDR_W'(4 * int'(REG_TIMEOUT_TICKS));
    localparam logic [31:0] COUNT_MASK =
        (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COUNT_BITS) - 32'd1);

    phase_t             rx_phase;
    logic               ready_step;
    logic [BYTE_W-1:0]  ack_tag_seq;
    logic [BYTE_W-1:0]  resp_tag_seq;
    logic [31:0]        bytes_left;
    logic [TICKS_W-1:0] quiet_ticks;
    logic [TICKS_W-1:0] timeout_limit;

    result_t awaited_replies[$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [BYTE_W-1:0] bump_low_nibble(input logic [BYTE_W-1:0] seq);
        return {seq[7:4], seq[3:0] + 4'd1};
    endfunction

    // Advances the receiver state by one input item and returns the reply it causes.
    function automatic result_t absorb_item(input logic [ACTION_W-1:0] action,
                                            input logic [BYTE_W-1:0] tag,
                                            input logic [BYTE_W-1:0] data,
                                            input logic [COUNT_W-1:0] count);
        result_t r;
        r = '0;
        r.event_res = EV_NONE;
        case (action)
            ACT_START_READY: begin
                rx_phase = PH_READY;
                ready_step = 1'b0;
                quiet_ticks = '0;
            end
            ACT_RX_WORD: begin
                if (rx_phase == PH_READY && data == READY_DATA
                        && tag == READY_TAG_BASE + BYTE_W'(ready_step)) begin
                    quiet_ticks = '0;
                    if (!ready_step) begin
                        ready_step = 1'b1;
                    end else begin
                        ready_step = 1'b0;
                        ack_tag_seq = ACK_SEQ_INIT;
                        resp_tag_seq = RESP_SEQ_INIT;
                        rx_phase = PH_IDLE;
                        r.event_res = EV_READY;
                    end
                end else if (rx_phase == PH_ACK && data == ACK_MARKER && tag == ack_tag_seq) begin
                    ack_tag_seq = bump_low_nibble(ack_tag_seq);
                    quiet_ticks = '0;
                    rx_phase = PH_IDLE;
                    r.event_res = EV_ACK;
                end else if (rx_phase == PH_BYTES && tag == resp_tag_seq) begin
                    resp_tag_seq = bump_low_nibble(resp_tag_seq);
                    quiet_ticks = '0;
                    r.data_byte = data;
                    r.event_res = EV_BYTE;
                    bytes_left = (bytes_left - 32'd1) & COUNT_MASK;
                    if (bytes_left == 0) begin
                        r.last = 1'b1;
                        rx_phase = PH_IDLE;
                    end
                end else begin
                    r.event_res = EV_IGNORED;
                end
            end
            ACT_EXPECT_ACK: begin
                rx_phase = PH_ACK;
                quiet_ticks = '0;
            end
            ACT_EXPECT_BYTES: begin
                bytes_left = 32'(count) & COUNT_MASK;
                quiet_ticks = '0;
                rx_phase = (bytes_left != 0) ? PH_BYTES : PH_IDLE;
            end
            ACT_TICK: begin
                if (rx_phase != PH_IDLE) begin
                    if (quiet_ticks >= timeout_limit) begin
                        rx_phase = PH_IDLE;
                        ready_step = 1'b0;
                        r.event_res = EV_TIMEOUT;
                    end else begin
                        quiet_ticks = quiet_ticks + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            rx_phase = PH_IDLE;
            ready_step = 1'b0;
            ack_tag_seq = ACK_SEQ_INIT;
            resp_tag_seq = RESP_SEQ_INIT;
            bytes_left = '0;
            quiet_ticks = '0;
            timeout_limit = TIMEOUT_RESET;
            awaited_replies.delete();
        end else begin
            // A result leaving this edge belongs to an item accepted at an earlier edge.
            if (m_tvalid && m_tready) begin
                if (awaited_replies.size() == 0) begin
                    $error("result transfer with nothing expected: m_tdata 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    report_field("event_res", 32'(want.event_res), 32'(m_tdata[2:0]));
                    report_field("data_byte", 32'(want.data_byte), 32'(m_tdata[10:3]));
                    report_field("last", 32'(want.last), 32'(m_tlast));
                    report_field("m_tdata padding", 32'd0, 32'(m_tdata[15:11]));
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_replies.push_back(absorb_item(s_tdata[2:0], s_tdata[10:3],
                                                      s_tdata[18:11], s_tdata[34:19]));
            end
            if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
                if (pwrite) begin
                    timeout_limit = pwdata[TICKS_W-1:0];
                end else begin
                    report_field("timeout_ticks", 32'(timeout_limit), prdata);
                end
            end
        end
        pending <= awaited_replies.size();
    end

endmodule

@@ verif/tagged_reply_word_receiver_unit_test.sv @@
// Testbench top for the tagged reply word receiver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tagged_reply_word_receiver_unit_test;
    import trwr_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = APB_ADDR_W'(4 * int'(REG_TIMEOUT_TICKS));
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_HI = 3'd7;
    localparam logic [TICKS_W-1:0] TIMEOUT_MIN = 24'd1;
    localparam logic [TICKS_W-1:0] TIMEOUT_MAX = 24'hFF_FFFF;
    localparam int TARGET_ITEMS = 550;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    int                    tx_idle_pct = 35;
    int                    rx_idle_pct = 35;
    bit                    stall_request = 1'b0;
    int                    items_sent = 0;
    logic [TICKS_W-1:0]    cur_timeout;
    logic [BYTE_W-1:0]     gen_ack;
    logic [BYTE_W-1:0]     gen_resp;

    tagged_reply_word_receiver_unit #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    reply_word_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) reply_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_request) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_request = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [BYTE_W-1:0] next_seq(input logic [BYTE_W-1:0] seq);
        return {seq[7:4], seq[3:0] + 4'd1};
    endfunction

    // s_tvalid stays high from one transfer into the next unless a gap is taken.
    task automatic offer_item(input logic [ACTION_W-1:0] action, input logic [BYTE_W-1:0] tag,
                              input logic [BYTE_W-1:0] data, input logic [COUNT_W-1:0] count);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tdata <= S_DATA_W'({count, data, tag, action});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_word(input logic [BYTE_W-1:0] tag, input logic [BYTE_W-1:0] data);
        offer_item(ACT_RX_WORD, tag, data, COUNT_W'($urandom));
    endtask

    task automatic send_tick();
        offer_item(ACT_TICK, BYTE_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= TIMEOUT_ADDR;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_timeout(input logic [TICKS_W-1:0] value);
        wait_idle();
        apb_access(1'b1, APB_DATA_W'(value));
        apb_access(1'b0, '0);
        cur_timeout = value;
    endtask

    // At most one stray word or one tick, so a matching sequence never times out.
    task automatic maybe_interfere(input logic [BYTE_W-1:0] want_tag);
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            send_word(want_tag ^ (8'd1 << $urandom_range(0, 7)), BYTE_W'($urandom));
        end else if (r < 20) begin
            send_tick();
        end
    endtask

    task automatic ready_handshake();
        offer_item(ACT_START_READY, BYTE_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
        maybe_interfere(READY_TAG_BASE);
        send_word(READY_TAG_BASE, READY_DATA);
        maybe_interfere(READY_TAG_BASE + 8'd1);
        send_word(READY_TAG_BASE + 8'd1, READY_DATA);
        gen_ack = ACK_SEQ_INIT;
        gen_resp = RESP_SEQ_INIT;
    endtask

    task automatic ack_exchange();
        offer_item(ACT_EXPECT_ACK, BYTE_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom));
        maybe_interfere(gen_ack);
        if ($urandom_range(9) == 0) begin
            send_word(gen_ack, ACK_MARKER ^ (8'd1 << $urandom_range(0, 7)));
        end
        send_word(gen_ack, ACK_MARKER);
        gen_ack = next_seq(gen_ack);
    endtask

    task automatic byte_run();
        int run_len;
        int sent_len;
        if ($urandom_range(19) == 0) begin
            offer_item(ACT_EXPECT_BYTES, BYTE_W'($urandom), BYTE_W'($urandom), '0);
            send_word(gen_resp, BYTE_W'($urandom));
        end else begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            sent_len = run_len;
            // Sometimes the next phase cuts the run short.
            if (run_len > 1 && $urandom_range(9) == 0) sent_len = $urandom_range(1, run_len - 1);
            offer_item(ACT_EXPECT_BYTES, BYTE_W'($urandom), BYTE_W'($urandom),
                       COUNT_W'(run_len));
            repeat (sent_len) begin
                maybe_interfere(gen_resp);
                send_word(gen_resp, BYTE_W'($urandom));
                gen_resp = next_seq(gen_resp);
            end
        end
    endtask

    task automatic timeout_run();
        int pick;
        pick = $urandom_range(2);
        if (pick == 0) begin
            offer_item(ACT_START_READY, BYTE_W'($urandom), BYTE_W'($urandom), '0);
        end else if (pick == 1) begin
            offer_item(ACT_EXPECT_ACK, BYTE_W'($urandom), BYTE_W'($urandom), '0);
        end else begin
            offer_item(ACT_EXPECT_BYTES, BYTE_W'($urandom), BYTE_W'($urandom),
                       COUNT_W'($urandom_range(1, 5)));
        end
        if (cur_timeout <= 24'd20) begin
            repeat (int'(cur_timeout) + 1) send_tick();
        end else begin
            repeat (3) send_tick();
        end
    endtask

    task automatic run_segment(input int n_items);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                ready_handshake();
            end else if (pick < 45) begin
                ack_exchange();
            end else if (pick < 75) begin
                byte_run();
            end else if (pick < 85) begin
                timeout_run();
            end else begin
                offer_item(ACTION_W'($urandom_range(0, 7)), BYTE_W'($urandom),
                           BYTE_W'($urandom), COUNT_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_timeout = TIMEOUT_RESET;
        gen_ack = ACK_SEQ_INIT;
        gen_resp = RESP_SEQ_INIT;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register readback at its reset value, then the shortest timeout.
        apb_access(1'b0, '0);
        set_timeout(TIMEOUT_MIN);

        // Idle block: ticks do nothing, words are ignored, unknown actions do nothing.
        offer_item(ACT_TICK, 8'h00, 8'h00, 16'h0000);
        send_word(8'hFF, 8'h00);
        for (int a = ACT_UNKNOWN_LO; a <= ACT_UNKNOWN_HI; a++) begin
            offer_item(ACTION_W'(a), 8'hFF, 8'hFF, 16'hFFFF);
        end
        // Ready wait with out-of-order and wrong-data words, then a tick that is not fatal.
        offer_item(ACT_START_READY, 8'h00, 8'h00, 16'h0000);
        send_word(READY_TAG_BASE + 8'd1, READY_DATA);
        send_word(READY_TAG_BASE, READY_DATA ^ 8'h01);
        send_word(READY_TAG_BASE, READY_DATA);
        offer_item(ACT_TICK, 8'h00, 8'h00, 16'h0000);
        send_word(READY_TAG_BASE + 8'd1, READY_DATA);
        // Ack with wrong data, then the right one; a second ack wait runs out of ticks.
        offer_item(ACT_EXPECT_ACK, 8'h00, 8'h00, 16'h0000);
        send_word(ACK_SEQ_INIT, ACK_MARKER ^ 8'h01);
        send_word(ACK_SEQ_INIT, ACK_MARKER);
        offer_item(ACT_EXPECT_ACK, 8'h00, 8'h00, 16'h0000);
        offer_item(ACT_TICK, 8'h00, 8'h00, 16'h0000);
        offer_item(ACT_TICK, 8'h00, 8'h00, 16'h0000);
        // A zero count leaves the block idle.
        offer_item(ACT_EXPECT_BYTES, 8'h00, 8'h00, 16'h0000);
        send_word(RESP_SEQ_INIT, 8'h55);
        // The largest run, cut off by a new phase.
        offer_item(ACT_EXPECT_BYTES, 8'h00, 8'h00, 16'hFFFF);
        send_word(RESP_SEQ_INIT, 8'hFF);
        send_word(RESP_SEQ_INIT + 8'd1, 8'h00);
        offer_item(ACT_START_READY, 8'h00, 8'h00, 16'h0000);
        // Single-byte run, then a two-byte run that opens with a stale tag.
        offer_item(ACT_EXPECT_BYTES, 8'h00, 8'h00, 16'h0001);
        send_word(RESP_SEQ_INIT + 8'd2, 8'h5A);
        offer_item(ACT_EXPECT_BYTES, 8'h00, 8'h00, 16'h0002);
        send_word(RESP_SEQ_INIT + 8'd2, 8'hA5);
        send_word(RESP_SEQ_INIT + 8'd3, 8'h01);
        send_word(RESP_SEQ_INIT + 8'd4, 8'h80);
        gen_ack = ACK_SEQ_INIT + 8'd1;
        gen_resp = RESP_SEQ_INIT + 8'd5;

        set_timeout(24'd3);
        run_segment(130);

        // Back-to-back stretch with no idling on either side, at the longest timeout.
        set_timeout(TIMEOUT_MAX);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_segment(110);
        tx_idle_pct = 35;
        rx_idle_pct = 35;

        // The receiver holds off while items keep coming, then the sender drains.
        set_timeout(TICKS_W'($urandom_range(2, 8)));
        stall_request = 1'b1;
        run_segment(20);
        wait_idle();
        run_segment(100);

        set_timeout(TIMEOUT_MIN);
        if (items_sent < TARGET_ITEMS) run_segment(TARGET_ITEMS - items_sent);

        wait_idle();
        if (pending != 0) $error("%0d results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
